// File: src/lmf_pkg.sv
// ----------------------------------------------------------------------------
// lmf_pkg: shared types and constants
// Types and defaults used by the luma median filter front, back and top level.
// ----------------------------------------------------------------------------
package lmf_pkg;

	localparam int MAX_WIDTH_D  = 1024;
	localparam int MAX_HEIGHT_D = 1024;
	localparam int MAX_RADIUS_D = 2;

	localparam int CFG_DW  = 11;
	localparam int CFG_IW  = 2;
	localparam int POS_W   = 13;	// holds a row/column count up to 4096
	localparam int COL_W   = 12;	// holds a column index below 4096
	localparam int SLOT_W  = 3;	// ring slot, ring is at most 8 rows
	localparam int RAD_W   = 2;

	localparam int JOB_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] luma;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic [7:0] alpha;
	} lmf_in_t;

	typedef struct packed {
		logic [7:0] out_luma;
		logic [7:0] out_chroma_blue;
		logic [7:0] out_chroma_red;
		logic [7:0] out_alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} lmf_out_t;

	// stored pixel, luma in the low byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] chroma_red;
		logic [7:0] chroma_blue;
		logic [7:0] luma;
	} lmf_pix_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [COL_W-1:0]  col;
		lmf_pix_t          pix;
	} lmf_mem_wr_t;

	// one output position to build
	typedef struct packed {
		logic [POS_W-1:0]  orow;
		logic [POS_W-1:0]  ocol;
		logic [POS_W-1:0]  w;
		logic [POS_W-1:0]  h;
		logic [SLOT_W-1:0] slot;
		logic [RAD_W-1:0]  r;
		logic              frame_end;
	} lmf_job_t;

endpackage

// File: src/lmf_fifo.sv
// ----------------------------------------------------------------------------
// lmf_fifo: small register queue
// Show-ahead queue, head on data_out while empty is low.
// ----------------------------------------------------------------------------
module lmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] data_in,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] data_out,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_wr, do_rd;

	assign full     = (cnt_q == CNW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_wr    = wr & ~full;
	assign do_rd    = rd & ~empty;
	assign data_out = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= data_in;
		end
	end
endmodule

// File: src/lmf_front.sv
// ----------------------------------------------------------------------------
// lmf_front: input side
// Holds config, stores pixels into the line ring, decides per beat whether
// an output position is complete and queues it for the back end.
// ----------------------------------------------------------------------------
module lmf_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  lmf_pkg::lmf_in_t            item,
	output logic                        full,
	input  logic                        cfg_valid,
	input  logic [lmf_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [lmf_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                        back_busy,
	input  logic                        job_full,
	output logic                        job_push,
	output lmf_pkg::lmf_job_t           job,
	output lmf_pkg::lmf_mem_wr_t        mem_wr
);
	import lmf_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int SW    = $clog2(RING);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	logic [CW-1:0]    w_q, w_cfg;
	logic [RW-1:0]    h_q, h_cfg;
	logic [RAD_W-1:0] r_q, r_cfg;
	logic [RW-1:0]    ir_q, or_q, ir_n;
	logic [XW-1:0]    ic_q, oc_q, ic_n;
	logic [SW-1:0]    islot_q, oslot_q, islot_n;
	logic             accept, wr, wrap, emit, fe;
	logic [CW-1:0]    ic_inc;
	logic [RW:0]      hm1, ly, orr;
	logic [CW:0]      wm1, lx, ocr;

	// config values are stored already clamped
	always_comb begin
		if (cfg_data == '0) begin
			w_cfg = CW'(1);
			h_cfg = RW'(1);
		end else begin
			w_cfg = (32'(cfg_data) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg_data);
			h_cfg = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_data);
		end
		r_cfg = (32'(cfg_data[RAD_W-1:0]) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
			: cfg_data[RAD_W-1:0];
	end

	assign full   = job_full | back_busy;
	assign accept = push & ~full;
	assign wr     = ~item.kind & (ir_q < h_q);
	assign ic_inc = CW'(ic_q) + 1'b1;
	assign wrap   = (ic_inc >= w_q);

	always_comb begin
		ic_n    = ic_q;
		ir_n    = ir_q;
		islot_n = islot_q;
		if (wr) begin
			ic_n = wrap ? '0 : ic_inc[XW-1:0];
			if (wrap) begin
				ir_n    = ir_q + 1'b1;
				islot_n = (islot_q == SW'(RING - 1)) ? '0 : islot_q + 1'b1;
			end
		end
	end

	// last row/column the window of the current output position needs
	assign hm1 = (RW+1)'(h_q) - 1'b1;
	assign wm1 = (CW+1)'(w_q) - 1'b1;
	assign orr = (RW+1)'(or_q) + (RW+1)'(r_q);
	assign ocr = (CW+1)'(oc_q) + (CW+1)'(r_q);
	assign ly  = (orr > hm1) ? hm1 : orr;
	assign lx  = (ocr > wm1) ? wm1 : ocr;

	assign emit = (or_q < h_q) && ((ir_n >= h_q) || ((RW+1)'(ir_n) > ly)
		|| (((RW+1)'(ir_n) == ly) && ((CW+1)'(ic_n) > lx)));
	assign fe   = ((RW+1)'(or_q) == hm1) && ((CW+1)'(oc_q) == wm1);

	assign job_push       = accept & emit;
	assign job.orow       = POS_W'(or_q);
	assign job.ocol       = POS_W'(oc_q);
	assign job.w          = POS_W'(w_q);
	assign job.h          = POS_W'(h_q);
	assign job.slot       = SLOT_W'(oslot_q);
	assign job.r          = r_q;
	assign job.frame_end  = fe;

	assign mem_wr.en                = accept & wr;
	assign mem_wr.slot              = SLOT_W'(islot_q);
	assign mem_wr.col               = COL_W'(ic_q);
	assign mem_wr.pix.luma          = item.luma;
	assign mem_wr.pix.chroma_blue   = item.chroma_blue;
	assign mem_wr.pix.chroma_red    = item.chroma_red;
	assign mem_wr.pix.alpha         = item.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= CW'(W_RST);
			h_q     <= RW'(H_RST);
			r_q     <= RAD_W'(1);
			ir_q    <= '0;
			ic_q    <= '0;
			or_q    <= '0;
			oc_q    <= '0;
			islot_q <= '0;
			oslot_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH: w_q <= w_cfg;
				REG_HEIGHT: h_q <= h_cfg;
				REG_RADIUS: r_q <= r_cfg;
				default: ;
			endcase
			if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
				|| cfg_index == REG_RADIUS) begin
				ir_q    <= '0;
				ic_q    <= '0;
				or_q    <= '0;
				oc_q    <= '0;
				islot_q <= '0;
				oslot_q <= '0;
			end
		end else if (accept) begin
			if (emit && fe) begin
				ir_q    <= '0;
				ic_q    <= '0;
				or_q    <= '0;
				oc_q    <= '0;
				islot_q <= '0;
				oslot_q <= '0;
			end else begin
				ir_q    <= ir_n;
				ic_q    <= ic_n;
				islot_q <= islot_n;
				if (emit) begin
					if ((CW+1)'(oc_q) == wm1) begin
						oc_q    <= '0;
						or_q    <= or_q + 1'b1;
						oslot_q <= (oslot_q == SW'(RING - 1)) ? '0 : oslot_q + 1'b1;
					end else begin
						oc_q <= oc_q + 1'b1;
					end
				end
			end
		end
	end
endmodule

// File: src/lmf_back.sv
// ----------------------------------------------------------------------------
// lmf_back: window gather, luma rank select and RGB rebuild
// Reads one window pixel per cycle from the line ring, keeps running ranks,
// picks the median rank and converts it to RGB.
// ----------------------------------------------------------------------------
module lmf_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lmf_pkg::lmf_mem_wr_t  mem_wr,
	input  logic                  job_empty,
	input  lmf_pkg::lmf_job_t     job_head,
	output logic                  job_pop,
	output logic                  gathering,
	input  logic                  out_full,
	output logic                  out_push,
	output lmf_pkg::lmf_out_t     out_data
);
	import lmf_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int RING = 2 * MAX_RADIUS + 2;
	localparam int SW   = $clog2(RING);
	localparam int KD   = 2 * MAX_RADIUS + 1;
	localparam int WMAX = KD * KD;
	localparam int NW   = $clog2(WMAX + 1);
	localparam int DW   = $clog2(KD);

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_GATHER = 3'd1;
	localparam logic [2:0] B_SELECT = 3'd2;
	localparam logic [2:0] B_MUL    = 3'd3;
	localparam logic [2:0] B_SUM    = 3'd4;

	// Rec.601 in Q16
	localparam logic signed [17:0] K_RCR = 18'sd91881;
	localparam logic signed [17:0] K_GCB = 18'sd22553;
	localparam logic signed [17:0] K_GCR = 18'sd46802;
	localparam logic signed [17:0] K_BCB = 18'sd116130;

	logic [31:0] mem [RING * (2 ** XW)];

	logic [2:0]      state_q;
	lmf_job_t        job_q;
	logic [DW-1:0]   dy_q, dx_q, two_r;
	logic            issue_done_q, rd_s1, rd_en, last_pos;
	logic [31:0]     rdata_s1;
	logic [NW-1:0]   n_q, rank_new, half;
	lmf_pix_t        win_q [WMAX];
	logic [NW-1:0]   rank_q [WMAX];
	logic [WMAX-1:0] le, up, match;
	lmf_pix_t        sel_pix, pix_s1;
	logic [RW-1:0]   orow, jh;
	logic [XW-1:0]   ocol;
	logic [CW-1:0]   jw;
	logic signed [RW+1:0] ys;
	logic signed [CW+1:0] xs;
	logic signed [SW+1:0] ss, ssf;
	logic            inb;
	logic [SW-1:0]   rslot;
	logic [7:0]      new_y;
	logic signed [8:0]  cbs, crs;
	logic signed [26:0] p_rcr_s2, p_gcb_s2, p_gcr_s2, p_bcb_s2;
	logic signed [28:0] base, sr, sg, sb;

	function automatic logic [7:0] clamp_q16(input logic signed [28:0] v);
		if (v < 0) begin
			return 8'd0;
		end else if (v[28:16] > 13'd255) begin
			return 8'd255;
		end else begin
			return v[23:16];
		end
	endfunction

	assign orow  = job_q.orow[RW-1:0];
	assign ocol  = job_q.ocol[XW-1:0];
	assign jh    = job_q.h[RW-1:0];
	assign jw    = job_q.w[CW-1:0];
	assign two_r = DW'({job_q.r, 1'b0});

	// window position to sample this cycle
	assign ys  = $signed((RW+2)'(orow)) + $signed((RW+2)'(dy_q)) - $signed((RW+2)'(job_q.r));
	assign xs  = $signed((CW+2)'(ocol)) + $signed((CW+2)'(dx_q)) - $signed((CW+2)'(job_q.r));
	assign inb = (ys >= 0) && (ys < $signed((RW+2)'(jh)))
		&& (xs >= 0) && (xs < $signed((CW+2)'(jw)));
	assign ss  = $signed((SW+2)'(job_q.slot)) + $signed((SW+2)'(dy_q))
		- $signed((SW+2)'(job_q.r));
	always_comb begin
		if (ss < 0) begin
			ssf = ss + $signed((SW+2)'(RING));
		end else if (ss >= $signed((SW+2)'(RING))) begin
			ssf = ss - $signed((SW+2)'(RING));
		end else begin
			ssf = ss;
		end
	end
	assign rslot    = ssf[SW-1:0];
	assign last_pos = (dy_q == two_r) && (dx_q == two_r);
	assign rd_en    = (state_q == B_GATHER) && !issue_done_q && inb;

	assign gathering = (state_q == B_GATHER);
	assign job_pop   = (state_q == B_IDLE) && !job_empty && !out_full;

	// running ranks: earlier entries rank lower on ties
	assign new_y = rdata_s1[7:0];
	always_comb begin
		rank_new = '0;
		for (int i = 0; i < WMAX; i++) begin
			le[i]    = (NW'(i) < n_q) && (win_q[i].luma <= new_y);
			up[i]    = (NW'(i) < n_q) && (new_y < win_q[i].luma);
			rank_new = rank_new + NW'(le[i]);
		end
	end

	assign half = n_q >> 1;
	always_comb begin
		sel_pix = '0;
		for (int i = 0; i < WMAX; i++) begin
			match[i] = (NW'(i) < n_q) && (rank_q[i] == half);
			if (match[i]) begin
				sel_pix = sel_pix | win_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[{mem_wr.slot[SW-1:0], mem_wr.col[XW-1:0]}] <= mem_wr.pix;
		end
		if (rd_en) begin
			rdata_s1 <= mem[{rslot, xs[XW-1:0]}];
		end
		if (job_pop) begin
			job_q <= job_head;
		end
		if (rd_s1) begin
			for (int i = 0; i < WMAX; i++) begin
				if (NW'(i) == n_q) begin
					win_q[i]  <= rdata_s1;
					rank_q[i] <= rank_new;
				end else if (up[i]) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
		if (state_q == B_SELECT) begin
			pix_s1 <= sel_pix;
		end
		if (state_q == B_MUL) begin
			p_rcr_s2 <= 27'(K_RCR * crs);
			p_gcb_s2 <= 27'(K_GCB * cbs);
			p_gcr_s2 <= 27'(K_GCR * crs);
			p_bcb_s2 <= 27'(K_BCB * cbs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			dy_q         <= '0;
			dx_q         <= '0;
			issue_done_q <= 1'b0;
			rd_s1        <= 1'b0;
			n_q          <= '0;
		end else begin
			rd_s1 <= rd_en;
			if (rd_s1) begin
				n_q <= n_q + 1'b1;
			end
			case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						state_q      <= B_GATHER;
						dy_q         <= '0;
						dx_q         <= '0;
						issue_done_q <= 1'b0;
						n_q          <= '0;
					end
				end
				B_GATHER: begin
					if (!issue_done_q) begin
						if (last_pos) begin
							issue_done_q <= 1'b1;
						end else if (dx_q == two_r) begin
							dx_q <= '0;
							dy_q <= dy_q + 1'b1;
						end else begin
							dx_q <= dx_q + 1'b1;
						end
					end else if (!rd_s1) begin
						state_q <= B_SELECT;
					end
				end
				B_SELECT: state_q <= B_MUL;
				B_MUL:    state_q <= B_SUM;
				B_SUM:    state_q <= B_IDLE;
				default:  state_q <= B_IDLE;
			endcase
		end
	end

	assign cbs  = $signed({1'b0, pix_s1.chroma_blue}) - 9'sd128;
	assign crs  = $signed({1'b0, pix_s1.chroma_red}) - 9'sd128;
	assign base = $signed({5'b0, pix_s1.luma, 16'b0});
	assign sr   = base + 29'(p_rcr_s2);
	assign sg   = base - 29'(p_gcb_s2) - 29'(p_gcr_s2);
	assign sb   = base + 29'(p_bcb_s2);

	assign out_push                 = (state_q == B_SUM);
	assign out_data.out_luma        = pix_s1.luma;
	assign out_data.out_chroma_blue = pix_s1.chroma_blue;
	assign out_data.out_chroma_red  = pix_s1.chroma_red;
	assign out_data.out_alpha       = pix_s1.alpha;
	assign out_data.red             = clamp_q16(sr);
	assign out_data.green           = clamp_q16(sg);
	assign out_data.blue            = clamp_q16(sb);
	assign out_data.frame_end       = job_q.frame_end;

	a_no_wr_in_gather: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> state_q != B_GATHER)
		else $error("line ring written while a window is being gathered");
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SELECT |-> $onehot(match))
		else $error("median rank not unique");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(WMAX))
		else $error("window count overflow");
	a_gather_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_GATHER && issue_done_q |=> state_q == B_GATHER || state_q == B_SELECT)
		else $error("bad exit from gather");
endmodule

// File: src/luma_median_filter_to_rgb.sv
// ----------------------------------------------------------------------------
// luma_median_filter_to_rgb: luma-ranked median filter with RGB rebuild
// Raster YCbCrA pixels in, median pixel of a square window plus RGB out.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | push / full               | item   (kind, Y, Cb, Cr, alpha)
//  result   | pop / empty               | result (median YCbCrA, RGB, frame_end)
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A beat that completes an output position queues a job; the back end then
//  gathers its window, one line ring read per window position inside the
//  frame, and ranks, selects and converts it. Input beats wait while a job
//  is queued or being gathered, since a new pixel may overwrite a ring row,
//  and longer still while the result queue is full.
//  Reset clears counters and control; the line ring needs no clearing.
//  cfg_ready is always high; writes to the width, height or radius register restart the frame.
// ----------------------------------------------------------------------------
module luma_median_filter_to_rgb #(
	parameter int MAX_WIDTH  = lmf_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = lmf_pkg::MAX_HEIGHT_D,
	parameter int MAX_RADIUS = lmf_pkg::MAX_RADIUS_D
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  lmf_pkg::lmf_in_t            item,
	output logic                        full,
	input  logic                        pop,
	output lmf_pkg::lmf_out_t           result,
	output logic                        empty,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lmf_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [lmf_pkg::CFG_DW-1:0]  cfg_data
);
	import lmf_pkg::*;

	lmf_job_t    job_in, job_head;
	lmf_mem_wr_t mem_wr;
	lmf_out_t    out_data;
	logic        job_push, job_pop, job_full, job_empty;
	logic        gathering, out_push, out_full;

	assign cfg_ready = 1'b1;

	// front: counters, config and pixel writes
	lmf_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item(item), .full(full),
		.cfg_valid(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.back_busy(gathering | ~job_empty),
		.job_full(job_full), .job_push(job_push), .job(job_in),
		.mem_wr(mem_wr)
	);

	// job queue between front and back
	lmf_fifo #(.WIDTH($bits(lmf_job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
		.clk(clk), .arst_n(arst_n),
		.wr(job_push), .data_in(job_in), .full(job_full),
		.rd(job_pop), .data_out(job_head), .empty(job_empty)
	);

	// back: gather, rank, select, convert
	lmf_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.mem_wr(mem_wr),
		.job_empty(job_empty), .job_head(job_head), .job_pop(job_pop),
		.gathering(gathering),
		.out_full(out_full), .out_push(out_push), .out_data(out_data)
	);

	// result queue, decouples the consumer from the back end
	lmf_fifo #(.WIDTH($bits(lmf_out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.wr(out_push), .data_in(out_data), .full(out_full),
		.rd(pop), .data_out(result), .empty(empty)
	);
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for luma_median_filter_to_rgb
// Streams raster frames of random YCbCrA pixels and flush beats through the
// filter at several frame sizes and window radii, predicts every median pixel
// and its RGB rebuild, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import lmf_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SETTLE_WAIT  = 64;
	localparam int HOLD_LEN     = 400;	// long receiver hold-off
	localparam int ITEM_BUDGET  = 1800;
	localparam int BROKEN_MAX   = 64;	// most pixels sent into an abandoned frame

	localparam int RING_ROWS = 2 * MAX_RADIUS_D + 2;
	localparam int WIN_MAX   = (2 * MAX_RADIUS_D + 1) * (2 * MAX_RADIUS_D + 1);

	localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;	// unused index, write is dropped

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	lmf_in_t item = '0;
	logic full;
	logic pop = 1'b0;
	lmf_out_t result;
	logic empty;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	luma_median_filter_to_rgb DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item(item), .full(full),
		.pop(pop), .result(result), .empty(empty),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ---- predictor state: shadow registers, counters and line ring ----
	logic [CFG_DW-1:0] shadow_width, shadow_height;
	logic [RAD_W-1:0]  shadow_radius;
	int in_row, in_col, out_row, out_col;
	lmf_pix_t line_ring [RING_ROWS * MAX_WIDTH_D];

	lmf_out_t median_q[$];	// medians still owed by the block

	int fail_count = 0;
	int cycles = 0;
	int snd_idle = 0;	// percent of cycles the sender sits idle
	int rcv_stall = 0;	// percent of cycles the receiver refuses a beat
	int hold_token = 0;
	int beats_sent = 0;

	function automatic int width_used();
		if (shadow_width == 0) return 1;
		return (shadow_width > MAX_WIDTH_D) ? MAX_WIDTH_D : int'(shadow_width);
	endfunction

	function automatic int height_used();
		if (shadow_height == 0) return 1;
		return (shadow_height > MAX_HEIGHT_D) ? MAX_HEIGHT_D : int'(shadow_height);
	endfunction

	function automatic int radius_used();
		return (shadow_radius > MAX_RADIUS_D) ? MAX_RADIUS_D : int'(shadow_radius);
	endfunction

	function automatic logic [7:0] q16_to_byte(longint v);
		if (v < 0) return 8'd0;
		v = v >>> 16;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic bit frame_idle();
		return in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
	endfunction

	// Advance the shadow filter by one accepted beat. A typed expectation,
	// when given, stands in for the computed one.
	task automatic predict_median(input lmf_in_t it, input bit typed, input lmf_out_t typed_val);
		int wu, hu, ru, ly, lx, n, pick, rank, y, x;
		lmf_pix_t win [WIN_MAX];
		lmf_pix_t px;
		lmf_out_t o;
		longint base, cb, cr;
		wu = width_used();
		hu = height_used();
		ru = radius_used();
		n = 0;
		pick = 0;
		if (it.kind == KIND_PIXEL && in_row < hu) begin
			px = '{alpha: it.alpha, chroma_red: it.chroma_red,
				chroma_blue: it.chroma_blue, luma: it.luma};
			line_ring[(in_row % RING_ROWS) * MAX_WIDTH_D + in_col] = px;
			in_col++;
			if (in_col >= wu) begin
				in_col = 0;
				in_row++;
			end
		end
		if (out_row >= hu) return;
		ly = (out_row + ru > hu - 1) ? hu - 1 : out_row + ru;
		lx = (out_col + ru > wu - 1) ? wu - 1 : out_col + ru;
		// window not complete yet: nothing to emit
		if (!(in_row >= hu || in_row > ly || (in_row == ly && in_col > lx))) return;

		for (int dy = -ru; dy <= ru; dy++) begin
			y = out_row + dy;
			if (y < 0 || y >= hu) continue;
			for (int dx = -ru; dx <= ru; dx++) begin
				x = out_col + dx;
				if (x < 0 || x >= wu) continue;
				win[n] = line_ring[(y % RING_ROWS) * MAX_WIDTH_D + x];
				n++;
			end
		end
		// rank by luma, equal luma ranks the earlier scan slot lower
		for (int i = 0; i < n; i++) begin
			rank = 0;
			for (int j = 0; j < n; j++)
				if (win[j].luma < win[i].luma || (win[j].luma == win[i].luma && j < i))
					rank++;
			if (rank == n / 2) begin
				pick = i;
				break;
			end
		end
		px = win[pick];
		base = longint'(px.luma) * 65536;
		cb = longint'(px.chroma_blue) - 128;
		cr = longint'(px.chroma_red) - 128;
		o.out_luma = px.luma;
		o.out_chroma_blue = px.chroma_blue;
		o.out_chroma_red = px.chroma_red;
		o.out_alpha = px.alpha;
		o.red = q16_to_byte(base + 91881 * cr);
		o.green = q16_to_byte(base - 22553 * cb - 46802 * cr);
		o.blue = q16_to_byte(base + 116130 * cb);
		o.frame_end = (out_row == hu - 1 && out_col == wu - 1);
		if (o.frame_end) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
		end else begin
			out_col++;
			if (out_col >= wu) begin
				out_col = 0;
				out_row++;
			end
		end
		median_q.insert(median_q.size(), typed ? typed_val : o);
	endtask

	function automatic void compare_field(string name, int e, int a);
		if (e != a) begin
			$error("%s mismatch: expected %0d, got %0d", name, e, a);
			fail_count++;
		end
	endfunction

	// ---- result side: random stalls plus a long hold-off on request ----
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		lmf_out_t e;
		if (pop && !empty) begin
			if (median_q.size() == 0) begin
				$error("result beat with no expectation waiting");
				fail_count++;
			end else begin
				e = median_q.pop_front();
				compare_field("out_luma", e.out_luma, result.out_luma);
				compare_field("out_chroma_blue", e.out_chroma_blue, result.out_chroma_blue);
				compare_field("out_chroma_red", e.out_chroma_red, result.out_chroma_red);
				compare_field("out_alpha", e.out_alpha, result.out_alpha);
				compare_field("red", e.red, result.red);
				compare_field("green", e.green, result.green);
				compare_field("blue", e.blue, result.blue);
				compare_field("frame_end", e.frame_end, result.frame_end);
			end
		end
		if (hold_seen != hold_token) begin
			hold_seen = hold_token;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else
			pop <= ($urandom_range(99) >= rcv_stall);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---- input side ----
	// push stays high from one beat to the next unless a gap is drawn
	task automatic send_beat(input lmf_in_t it, input bit typed = 1'b0,
			input lmf_out_t typed_val = '0);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		beats_sent++;
		predict_median(it, typed, typed_val);
	endtask

	// sender pause: nothing owed and the back end has gone quiet
	task automatic wait_drained();
		push <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH:  shadow_width = val;
			REG_HEIGHT: shadow_height = val;
			REG_RADIUS: shadow_radius = val[RAD_W-1:0];
			default: ;
		endcase
		if (idx != REG_SPARE) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
		end
	endtask

	function automatic lmf_in_t random_pixel();
		lmf_in_t p;
		p = ($bits(lmf_in_t))'($urandom);
		p.kind = KIND_PIXEL;
		// a narrow luma set now and then, so ties get ranked often
		if ($urandom_range(3) == 0) p.luma = 8'(8 * $urandom_range(3));
		return p;
	endfunction

	// One frame: configure, stream pixels with stray flushes, then drain.
	// A broken frame stops part way and is abandoned by the next write.
	task automatic run_frame(input int wr, input int hr, input int rr, input bit broken,
			input bit squeeze = 1'b0);
		int npix;
		lmf_in_t fl;
		write_reg(REG_WIDTH, CFG_DW'(wr));
		write_reg(REG_HEIGHT, CFG_DW'(hr));
		write_reg(REG_RADIUS, CFG_DW'(rr));
		if (squeeze) hold_token++;	// receiver holds off, input backs up
		npix = width_used() * height_used();
		if (broken) npix = $urandom_range(1, (npix < BROKEN_MAX) ? npix : BROKEN_MAX);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(9) == 0) begin
				fl = ($bits(lmf_in_t))'($urandom);
				fl.kind = KIND_FLUSH;
				send_beat(fl);
			end
			send_beat(random_pixel());
			if (squeeze && i == npix / 2) wait_drained();
		end
		if (broken) return;
		// tail of the frame: flushes, and pixels that the block ignores
		while (!frame_idle()) begin
			fl = ($bits(lmf_in_t))'($urandom);
			if ($urandom_range(3) != 0) fl.kind = KIND_FLUSH;
			send_beat(fl);
		end
	endtask

	typedef struct {
		lmf_in_t  beat;
		bit       typed;
		lmf_out_t want;
	} directed_row_t;

	// 1x1 frame, radius 0: every pixel is its own median and ends the frame
	directed_row_t directed_rows [] = '{
		'{'{KIND_PIXEL, 8'd0, 8'd128, 8'd128, 8'd0}, 1'b1,
			'{8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
		'{'{KIND_PIXEL, 8'd255, 8'd128, 8'd128, 8'd255}, 1'b1,
			'{8'd255, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
		'{'{KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd135, 8'd0, 1'b1}},
		'{'{KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
			'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd120, 8'd255, 1'b1}},
		'{'{KIND_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},	// nothing ready
		'{'{KIND_PIXEL, 8'd0, 8'd255, 8'd0, 8'd170}, 1'b0, '0},
		'{'{KIND_PIXEL, 8'd255, 8'd0, 8'd255, 8'd85}, 1'b0, '0},
		'{'{KIND_FLUSH, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
		'{'{KIND_PIXEL, 8'd128, 8'd64, 8'd192, 8'd1}, 1'b0, '0}
	};

	initial begin
		int sizes [4][3];
		int base_beats;
		lmf_in_t p;
		// reset state of the registers
		shadow_width = 11'd1024;
		shadow_height = 11'd1024;
		shadow_radius = 2'd1;
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: colour extremes, flush with nothing ready
		write_reg(REG_SPARE, 11'h7FF);
		write_reg(REG_WIDTH, 11'd1);
		write_reg(REG_HEIGHT, 11'd1);
		write_reg(REG_RADIUS, 2'd0);
		foreach (directed_rows[k])
			send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

		// directed: 3x3 frame, radius saturates to 2, all luma equal so ties pick by scan
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd3);
		write_reg(REG_RADIUS, 2'd3);
		for (int i = 0; i < 9; i++) begin
			p = '{KIND_PIXEL, 8'd100, 8'(i * 20), 8'(255 - i * 20), 8'(i)};
			send_beat(p);
		end
		// pixels past the frame act as flushes until the last output
		while (!frame_idle()) begin
			p = ($bits(lmf_in_t))'($urandom);
			p.kind = KIND_PIXEL;
			send_beat(p);
		end

		// register extremes: zero sizes, oversize, max and saturating radius;
		// the tall frame is cut short and abandoned
		sizes = '{'{0, 0, 0}, '{2047, 1, 3}, '{1, 2047, 2}, '{3, 2, 0}};
		foreach (sizes[k])
			run_frame(sizes[k][0], sizes[k][1], sizes[k][2], k == 2);

		// random frames over the idling phases
		base_beats = beats_sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin snd_idle = 0;  rcv_stall = 0;  end
				1: begin snd_idle = 45; rcv_stall = 0;  end
				2: begin snd_idle = 0;  rcv_stall = 45; end
				default: begin snd_idle = 28; rcv_stall = 28; end
			endcase
			if (phase == 0) run_frame(8, 6, 1, 1'b0, 1'b1);
			while (beats_sent - base_beats < (ITEM_BUDGET - base_beats) * (phase + 1) / 4)
				run_frame($urandom_range(1, 12), $urandom_range(1, 8),
					$urandom_range(0, 3), $urandom_range(9) == 0);
		end

		wait_drained();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
